### rtl/npc_pkg.sv
// Shared types, widths and the fixed 16-color VGA palette for the quantizer.
`timescale 1ns / 1ps

package npc_pkg;

  localparam int PAL_SIZE = 16;
  localparam int IDX_W    = 4;
  localparam int CH_W     = 8;
  localparam int SQ_W     = 2 * CH_W;
  localparam int DIST_W   = 18;  // 3 * 255^2 = 195075 fits

  // Pixel plus the best match found so far, handed from cell to cell.
  typedef struct packed {
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_err;
  } npc_token_t;

  // Palette entry as {red, green, blue}.
  function automatic logic [3*CH_W-1:0] pal_color(input logic [IDX_W-1:0] idx);
    logic [3*CH_W-1:0] c;
    case (idx)
      4'd0:    c = {8'd0,   8'd0,   8'd0};
      4'd1:    c = {8'd0,   8'd0,   8'd170};
      4'd2:    c = {8'd0,   8'd170, 8'd0};
      4'd3:    c = {8'd0,   8'd170, 8'd170};
      4'd4:    c = {8'd170, 8'd0,   8'd0};
      4'd5:    c = {8'd170, 8'd0,   8'd170};
      4'd6:    c = {8'd170, 8'd85,  8'd0};
      4'd7:    c = {8'd170, 8'd170, 8'd170};
      4'd8:    c = {8'd85,  8'd85,  8'd85};
      4'd9:    c = {8'd85,  8'd85,  8'd255};
      4'd10:   c = {8'd85,  8'd255, 8'd85};
      4'd11:   c = {8'd85,  8'd255, 8'd255};
      4'd12:   c = {8'd255, 8'd85,  8'd85};
      4'd13:   c = {8'd255, 8'd85,  8'd255};
      4'd14:   c = {8'd255, 8'd255, 8'd85};
      default: c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

endpackage

### rtl/nearest_palette_color.sv
// Top level: 16-cell chain that maps an RGB pixel to the nearest VGA palette index.
//
// Usage: pixels enter on in_red/in_green/in_blue with in_valid/in_ready;
// the palette index leaves on out_color_index with out_valid/out_ready.
// A transaction happens on a rising edge where valid and ready are both high.
// Each of the 16 cells owns one palette color; the pixel walks the chain one
// cell per cycle while the output is not stalled, carrying the best index and
// distance found so far. Ties keep the lower index.
// The first cell captures at the input transaction edge, then each further
// cell registers the pixel in turn until the last cell raises out_valid.
// Throughput: one pixel per cycle while not stalled; each cell can hold a different pixel.
// Stall: while out_valid is high and out_ready low, the whole chain freezes
// and in_ready drops in the same cycle; nothing is dropped or repeated.
// The last cell's register is the output register.
// Reset (rst_n low, synchronous): all cell valid bits clear, so the chain
// comes up empty with in_ready high. The palette is fixed; no configuration.
`timescale 1ns / 1ps

module nearest_palette_color (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [npc_pkg::CH_W-1:0]        in_red,
  input  logic [npc_pkg::CH_W-1:0]        in_green,
  input  logic [npc_pkg::CH_W-1:0]        in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [npc_pkg::IDX_W-1:0]       out_color_index
);

  logic                vld [npc_pkg::PAL_SIZE+1];
  npc_pkg::npc_token_t tok [npc_pkg::PAL_SIZE+1];
  logic                advance;

  assign advance = !vld[npc_pkg::PAL_SIZE] || out_ready;
  assign in_ready = advance;

  assign vld[0] = in_valid;
  assign tok[0] = {in_red, in_green, in_blue, npc_pkg::IDX_W'(0), npc_pkg::DIST_W'(0)};

  for (genvar k = 0; k < npc_pkg::PAL_SIZE; k++) begin : g_cell
    npc_cell #(
      .INDEX(npc_pkg::IDX_W'(k))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .in_vld (vld[k]),
      .in_tok (tok[k]),
      .out_vld(vld[k+1]),
      .out_tok(tok[k+1])
    );
  end

  assign out_valid       = vld[npc_pkg::PAL_SIZE];
  assign out_color_index = tok[npc_pkg::PAL_SIZE].best_idx;

endmodule

### rtl/npc_cell.sv
// One palette cell: distance to its own color, keeps the better of that and the incoming best.
`timescale 1ns / 1ps

module npc_cell #(
  parameter logic [npc_pkg::IDX_W-1:0] INDEX = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  npc_pkg::npc_token_t in_tok,
  output logic                out_vld,
  output npc_pkg::npc_token_t out_tok
);

  localparam logic [3*npc_pkg::CH_W-1:0] COLOR = npc_pkg::pal_color(INDEX);
  localparam logic [npc_pkg::CH_W-1:0] C_RED   = COLOR[3*npc_pkg::CH_W-1:2*npc_pkg::CH_W];
  localparam logic [npc_pkg::CH_W-1:0] C_GREEN = COLOR[2*npc_pkg::CH_W-1:npc_pkg::CH_W];
  localparam logic [npc_pkg::CH_W-1:0] C_BLUE  = COLOR[npc_pkg::CH_W-1:0];

  function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
    input logic [npc_pkg::CH_W-1:0] a,
    input logic [npc_pkg::CH_W-1:0] b
  );
    logic [npc_pkg::CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  logic [npc_pkg::DIST_W-1:0] err;
  logic                       take;
  logic                       vld_r;
  npc_pkg::npc_token_t        tok_r;
  npc_pkg::npc_token_t        tok_nxt;

  always_comb begin
    err = npc_pkg::DIST_W'(sq_diff(in_tok.red, C_RED))
        + npc_pkg::DIST_W'(sq_diff(in_tok.green, C_GREEN))
        + npc_pkg::DIST_W'(sq_diff(in_tok.blue, C_BLUE));
    // first cell always takes; later cells only on a strictly smaller distance
    take = (INDEX == '0) || (err < in_tok.best_err);
    tok_nxt = in_tok;
    if (take) begin
      tok_nxt.best_idx = INDEX;
      tok_nxt.best_err = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

### rtl/npc_checker.sv
// Port-level checks for the palette quantizer, bound to the top level.
`timescale 1ns / 1ps

module npc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [npc_pkg::IDX_W-1:0] out_color_index
);

  // chain comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out_valid high right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color_index))
    else $error("stalled result changed or vanished");

  // empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with no result pending");

  // a stalled output freezes the chain, so nothing new may enter
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_color_index(out_color_index)
);
